FILE: src/ghsd_pkg.sv
// Shared types and constants for the heat grid block.
// Used by ghsd_ctrl, ghsd_dp and grid_heat_splat_decay; no dependencies.
`default_nettype none
package ghsd_pkg;

    typedef enum logic [1:0] {
        OP_PAINT = 2'd0,
        OP_DECAY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_SWEEP,
        ST_QUERY,
        ST_DRAIN,
        ST_DONE
    } state_t;

    localparam logic [2:0] CFG_HARDNESS = 3'd0;
    localparam logic [2:0] CFG_RATE     = 3'd1;
    localparam logic [2:0] CFG_FLOOR    = 3'd2;
    localparam logic [2:0] CFG_CEILING  = 3'd3;
    localparam logic [2:0] CFG_COLS     = 3'd4;
    localparam logic [2:0] CFG_ROWS     = 3'd5;

    localparam int W_W      = 16;   // weight width
    localparam int TOT_W    = 26;
    localparam int TILE_W   = 10;
    localparam int IDX_W    = 16;   // internal store index
    localparam int DIM_W    = 9;    // saturated grid dimension
    localparam int CRD_W    = 12;   // signed paint coordinates
    localparam int OFS_W    = 7;    // signed window offset
    localparam int RAD_W    = 5;
    localparam int DIST_W   = 6;
    localparam int BASE_W   = 17;   // (value * time) >> 15
    localparam int RECIP_N  = 64;
    localparam int RECIP_W  = 24;
    localparam int RECIP_SH = 23;
    localparam int PROD_W   = BASE_W + RECIP_W;
    localparam int DIV_STEPS = 10;
    localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic walk_step;
        logic sweep_step;
        logic sweep_zero;
        logic query_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic rate_zero;
        logic walk_last;
        logic sweep_last;
        logic pipe_empty;
    } sts_t;

endpackage
`default_nettype wire

FILE: src/ghsd_ctrl.sv
// Sequencer for the heat grid: walks each operation through its phases.
// Depends on ghsd_pkg; drives ghsd_dp through cmd_t, reads sts_t.
`default_nettype none
module ghsd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    op,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ghsd_pkg::cmd_t     cmd,
    input  wire ghsd_pkg::sts_t sts
);

    ghsd_pkg::state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ghsd_pkg::ST_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ghsd_pkg::ST_INIT:
            begin
                if (sts.sweep_last)
                    state_next = ghsd_pkg::ST_IDLE;
            end
            ghsd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next = '0;
                    case (ghsd_pkg::op_t'(op))
                        ghsd_pkg::OP_PAINT: state_next = ghsd_pkg::ST_DIV;
                        ghsd_pkg::OP_DECAY:
                            state_next = sts.rate_zero ? ghsd_pkg::ST_DONE
                                                       : ghsd_pkg::ST_SWEEP;
                        ghsd_pkg::OP_CLEAR: state_next = ghsd_pkg::ST_SWEEP;
                        default:            state_next = ghsd_pkg::ST_QUERY;
                    endcase
                end
            end
            ghsd_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(ghsd_pkg::DIV_STEPS - 1))
                    state_next = ghsd_pkg::ST_WALK;
            end
            ghsd_pkg::ST_WALK:
            begin
                if (sts.walk_last)
                    state_next = ghsd_pkg::ST_DRAIN;
            end
            ghsd_pkg::ST_SWEEP:
            begin
                if (sts.sweep_last)
                    state_next = ghsd_pkg::ST_DRAIN;
            end
            ghsd_pkg::ST_QUERY: state_next = ghsd_pkg::ST_DONE;
            ghsd_pkg::ST_DRAIN:
            begin
                if (sts.pipe_empty)
                    state_next = ghsd_pkg::ST_DONE;
            end
            ghsd_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = ghsd_pkg::ST_IDLE;
            end
            default: state_next = ghsd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ghsd_pkg::ST_INIT:
            begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_zero = 1'b1;
            end
            ghsd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ghsd_pkg::ST_DIV:   cmd.div_step   = 1'b1;
            ghsd_pkg::ST_WALK:  cmd.walk_step  = 1'b1;
            ghsd_pkg::ST_SWEEP: cmd.sweep_step = 1'b1;
            ghsd_pkg::ST_QUERY: cmd.query_rd   = 1'b1;
            ghsd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/ghsd_dp.sv
// Datapath of the heat grid: config registers, weight store, divider,
// paint walker, sweep counter, update pipeline, stats and result word.
// Depends on ghsd_pkg; controlled by ghsd_ctrl.
`default_nettype none
module ghsd_dp #(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [1:0]  op,
    input  wire logic [9:0]  tile_index,
    input  wire logic [2:0]  radius,
    input  wire logic [15:0] time_scale,
    input  wire ghsd_pkg::cmd_t cmd,
    output ghsd_pkg::sts_t   sts,
    output logic [15:0]      tile_weight,
    output logic             index_valid,
    output logic [25:0]      heat_total,
    output logic [15:0]      peak_weight,
    output logic [9:0]       peak_tile
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W     = ghsd_pkg::W_W;
    localparam int IW    = ghsd_pkg::IDX_W;
    localparam int DW    = ghsd_pkg::DIM_W;
    localparam int CW    = ghsd_pkg::CRD_W;
    localparam int OW    = ghsd_pkg::OFS_W;

    // configuration
    logic [W-1:0] hard_reg, rate_reg, floor_reg, ceil_reg;
    logic [5:0]   cols_reg, rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hard_reg  <= '0;
            rate_reg  <= '0;
            floor_reg <= '0;
            ceil_reg  <= '1;
            cols_reg  <= 6'd32;
            rows_reg  <= 6'd32;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ghsd_pkg::CFG_HARDNESS: hard_reg  <= cfg_data;
                ghsd_pkg::CFG_RATE:     rate_reg  <= cfg_data;
                ghsd_pkg::CFG_FLOOR:    floor_reg <= cfg_data;
                ghsd_pkg::CFG_CEILING:  ceil_reg  <= cfg_data;
                ghsd_pkg::CFG_COLS:     cols_reg  <= cfg_data[5:0];
                ghsd_pkg::CFG_ROWS:     rows_reg  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [DW-1:0] cols, rows;
    assign cols = (cols_reg == 6'd0) ? DW'(1)
                : ({3'b0, cols_reg} > DW'(MAX_COLS)) ? DW'(MAX_COLS) : {3'b0, cols_reg};
    assign rows = (rows_reg == 6'd0) ? DW'(1)
                : ({3'b0, rows_reg} > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : {3'b0, rows_reg};

    // per-item registers
    ghsd_pkg::op_t               op_reg;
    logic [9:0]                  tile_reg;
    logic [31:0]                 mult_reg;
    logic [ghsd_pkg::RAD_W-1:0]  r_reg;
    logic [ghsd_pkg::RAD_W-1:0]  r_in;
    logic [ghsd_pkg::BASE_W-1:0] base;

    assign r_in = ({2'b0, radius} > ghsd_pkg::RAD_W'(MAX_RADIUS))
                ? ghsd_pkg::RAD_W'(MAX_RADIUS) : {2'b0, radius};
    assign base = mult_reg[31:15];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= ghsd_pkg::op_t'(op);
            tile_reg <= tile_index;
            r_reg    <= r_in;
            mult_reg <= ((ghsd_pkg::op_t'(op) == ghsd_pkg::OP_DECAY) ? rate_reg : hard_reg)
                        * time_scale;
        end
    end

    // restoring divider: tile / cols
    logic [9:0]    quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[9]};
    assign fits  = trial >= {1'b0, cols};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg <= tile_index;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, cols}) : trial[DW-1:0];
            quo_reg <= {quo_reg[8:0], fits};
        end
    end

    // paint window walker
    logic signed [OW-1:0] ox_reg, oy_reg, r_s;
    logic signed [CW-1:0] x, y;
    logic [ghsd_pkg::DIST_W-1:0] win_dist;
    logic [OW-1:0] ax, ay;
    logic          in_grid;
    logic [17:0]   walk_idx;

    assign r_s = $signed({2'b0, r_reg});
    assign x   = $signed({3'b0, rem_reg}) + CW'(ox_reg);
    assign y   = $signed({2'b0, quo_reg}) + CW'(oy_reg);
    assign ax  = ox_reg[OW-1] ? OW'(-ox_reg) : ox_reg;
    assign ay  = oy_reg[OW-1] ? OW'(-oy_reg) : oy_reg;
    assign win_dist = ghsd_pkg::DIST_W'(ax + ay);
    assign in_grid = (x >= 0) && (x < $signed({3'b0, cols}))
                  && (y >= 0) && (y < $signed({3'b0, rows}));
    assign walk_idx = 18'(y[7:0] * cols) + 18'(x[8:0]);
    assign sts.walk_last = (ox_reg == r_s) && (oy_reg == r_s);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ox_reg <= -$signed({2'b0, r_in});
            oy_reg <= -$signed({2'b0, r_in});
        end
        else if (cmd.walk_step)
        begin
            if (ox_reg == r_s)
            begin
                ox_reg <= -r_s;
                oy_reg <= oy_reg + OW'(1);
            end
            else
                ox_reg <= ox_reg + OW'(1);
        end
    end

    // sweep counter, also runs the clearing pass after reset
    logic [IW-1:0] sweep_reg;
    assign sts.sweep_last = sweep_reg == IW'(DEPTH - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else if (cmd.load)
            sweep_reg <= '0;
        else if (cmd.sweep_step)
            sweep_reg <= sweep_reg + IW'(1);
    end

    // reciprocal table: ceil(2^23 / (d + 1))
    logic [ghsd_pkg::RECIP_W-1:0] recip_tab [ghsd_pkg::RECIP_N];
    for (genvar n = 0; n < ghsd_pkg::RECIP_N; n++)
    begin : g_recip
        localparam logic [ghsd_pkg::RECIP_W-1:0] M =
            ghsd_pkg::RECIP_W'(((2 ** ghsd_pkg::RECIP_SH) + n) / (n + 1));
        assign recip_tab[n] = M;
    end

    // store and update pipeline
    logic [W-1:0]  mem [DEPTH];
    logic [W-1:0]  rd_q;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [W-1:0]  wr_data;

    logic                 issue;
    logic                 p1_valid_reg, p2_valid_reg;
    logic [IW-1:0]        p1_addr_reg, p2_addr_reg;
    logic [ghsd_pkg::DIST_W-1:0] p1_d_reg;
    logic [W-1:0]         p2_w_reg, p2_v_reg;
    logic [ghsd_pkg::PROD_W-1:0] p2_prod_reg;
    logic [W-1:0]         dec_v;
    logic [ghsd_pkg::BASE_W:0] dsub;
    logic                 p2_keep;
    logic                 q_ok_reg;
    logic                 q_ok;

    logic          sweep_wr;
    logic          is_decay;
    logic [17:0]   cells;

    assign is_decay = op_reg == ghsd_pkg::OP_DECAY;
    assign sweep_wr = cmd.sweep_step && (cmd.sweep_zero || op_reg == ghsd_pkg::OP_CLEAR);
    assign issue = (cmd.walk_step && in_grid) || (cmd.sweep_step && !cmd.sweep_zero && is_decay);
    assign cells = cols * rows;
    assign q_ok  = {8'b0, tile_reg} < cells;

    always_comb
    begin
        rd_en   = issue || cmd.query_rd;
        rd_addr = cmd.walk_step ? walk_idx[IW-1:0]
                : cmd.query_rd ? IW'(tile_reg) : sweep_reg;
    end

    // decay of one cell, and whether the cell is written back
    always_comb
    begin
        dsub = {2'b0, rd_q} - {1'b0, base};
        dec_v = dsub[ghsd_pkg::BASE_W] ? '0 : dsub[W-1:0];
        if (dec_v < floor_reg)
            dec_v = floor_reg;
        if (dec_v > ceil_reg)
            dec_v = ceil_reg;
        p2_keep = is_decay ? (rd_q != '0) : (rd_q < ceil_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg && p2_keep;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_addr_reg <= rd_addr;
        p1_d_reg    <= win_dist;
        p2_addr_reg <= p1_addr_reg;
        p2_w_reg    <= rd_q;
        p2_v_reg    <= dec_v;
        p2_prod_reg <= base * recip_tab[p1_d_reg];
        if (cmd.query_rd)
            q_ok_reg <= q_ok;
    end

    // final stage: clip gain, write back, update stats
    logic [ghsd_pkg::TOT_W-1:0] heat_reg_total;
    logic [W-1:0]               peak_reg;
    logic [9:0]                 pos_reg;
    logic [ghsd_pkg::PROD_W-ghsd_pkg::RECIP_SH-1:0] gain;
    logic [W-1:0] head, add_v, new_w;
    logic [ghsd_pkg::TOT_W:0] tsum;

    assign gain  = p2_prod_reg[ghsd_pkg::PROD_W-1:ghsd_pkg::RECIP_SH];
    assign head  = ceil_reg - p2_w_reg;
    assign add_v = is_decay ? p2_v_reg
                 : (gain > 18'(head)) ? head : gain[W-1:0];
    assign new_w = is_decay ? p2_v_reg : p2_w_reg + add_v;
    assign tsum  = {1'b0, heat_reg_total} + (ghsd_pkg::TOT_W + 1)'(add_v);

    always_comb
    begin
        wr_en   = p2_valid_reg || sweep_wr;
        wr_addr = p2_valid_reg ? p2_addr_reg : sweep_reg;
        wr_data = p2_valid_reg ? new_w : (cmd.sweep_zero ? '0 : floor_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[AW-1:0]] <= wr_data;
        if (rd_en)
            rd_q <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_reg_total <= '0;
            peak_reg       <= '0;
            pos_reg        <= '0;
        end
        else if (cmd.load && ghsd_pkg::op_t'(op) == ghsd_pkg::OP_CLEAR)
        begin
            heat_reg_total <= '0;
            peak_reg       <= '0;
            pos_reg        <= '0;
        end
        else if (cmd.load && ghsd_pkg::op_t'(op) == ghsd_pkg::OP_DECAY && rate_reg != '0)
        begin
            heat_reg_total <= '0;
            peak_reg       <= '0;
        end
        else if (p2_valid_reg)
        begin
            heat_reg_total <= tsum[ghsd_pkg::TOT_W] ? ghsd_pkg::TOTAL_MAX
                                                    : tsum[ghsd_pkg::TOT_W-1:0];
            if (new_w > peak_reg)
            begin
                peak_reg <= new_w;
                pos_reg  <= p2_addr_reg[9:0];
            end
        end
    end

    assign sts.rate_zero  = rate_reg == '0;
    assign sts.pipe_empty = !p1_valid_reg && !p2_valid_reg;

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            tile_weight <= (op_reg == ghsd_pkg::OP_QUERY && q_ok_reg) ? rd_q : '0;
            index_valid <= op_reg == ghsd_pkg::OP_QUERY && q_ok_reg;
            heat_total  <= heat_reg_total;
            peak_weight <= peak_reg;
            peak_tile   <= pos_reg;
        end
    end

endmodule
`default_nettype wire

FILE: src/grid_heat_splat_decay.sv
// Top level of the heat grid block: sequencer plus datapath.
// Depends on ghsd_pkg, ghsd_ctrl and ghsd_dp.
//
// Channels: an input word (op, tile_index, radius, time_scale) on
// in_valid/in_ready, one result word per input on out_valid/out_ready,
// and a register write port on cfg_valid/cfg_ready (always ready).
// One item at a time. Steps per item, from acceptance to result valid:
//   query  one store read
//   paint  the 10-step divider, then one window cell per cycle through a
//          three-stage read/update/write pipeline, then a pipeline drain
//   decay  a sweep over all MAX_COLS*MAX_ROWS store entries (one per cycle)
//          and a pipeline drain; skipped with rate 0
//   clear  a sweep over all MAX_COLS*MAX_ROWS store entries, then a drain
// plus a return to idle. The store sweep sets the rate
// of decay and clear.
// Reset: a clearing pass over all MAX_COLS*MAX_ROWS entries zeroes the store;
// in_ready stays low meanwhile. A finished result sits in the output
// register; the next word is accepted while it waits, and the block holds
// its following result until the receiver takes the first.
`default_nettype none
module grid_heat_splat_decay #(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [9:0]  tile_index,
    input  wire logic [2:0]  radius,
    input  wire logic [15:0] time_scale,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      tile_weight,
    output logic             index_valid,
    output logic [25:0]      heat_total,
    output logic [15:0]      peak_weight,
    output logic [9:0]       peak_tile
);

    ghsd_pkg::cmd_t cmd;
    ghsd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    ghsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ghsd_dp #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .tile_index  (tile_index),
        .radius      (radius),
        .time_scale  (time_scale),
        .cmd         (cmd),
        .sts         (sts),
        .tile_weight (tile_weight),
        .index_valid (index_valid),
        .heat_total  (heat_total),
        .peak_weight (peak_weight),
        .peak_tile   (peak_tile)
    );

endmodule
`default_nettype wire
